### rtl/vsn_pkg.sv
// Shared types, constants and helpers for the vertex store nearest-select block.
package vsn_pkg;

    localparam int VSN_MAX_VERTS  = 64;
    localparam int VSN_COORD_BITS = 16;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;

    // Result word layout, lowest bit up.
    localparam int OUT_IDX_BITS = 6;
    localparam int OUT_DW       = 16;

    // Per-cell control: rotate the ring, or load the incoming point.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    function automatic logic [OUT_DW-1:0] pack_out(
        input logic                    applied,
        input logic                    sel_valid,
        input logic [OUT_IDX_BITS-1:0] sel_idx,
        input logic [OUT_IDX_BITS-1:0] count
    );
        logic [OUT_DW-1:0] w;
        w = '0;
        w[0]   = applied;
        w[1]   = sel_valid;
        w[7:2] = sel_idx;
        w[13:8] = count;
        return w;
    endfunction

endpackage

### rtl/vertex_store_nearest_select_core.sv
// Top level of the vertex store with nearest-vertex selection.
// Add, move and unused codes: result word is valid in the cycle after the word is taken.
// Select on a non-empty store: the result follows one full rotation of the
// cell ring past the single distance pipeline, then its three stages and a finish state.
// One input word is worked on at a time; a new word is taken once the result slot is free.
// Reset is synchronous, active low: count and selection clear, the vertex cells do not.
module vertex_store_nearest_select_core
    import vsn_pkg::*;
#(
    parameter int MAX_VERTS  = VSN_MAX_VERTS,
    parameter int COORD_BITS = VSN_COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: x_coord, then y_coord, zero filled to whole bytes.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // tuser: operation.
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: applied, selection_valid, selected_index, vertex_count, zero filled.
    output logic [OUT_DW-1:0]                     m_axis_tdata
);

    localparam int CB = COORD_BITS;
    localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int N  = MAX_VERTS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // Control state.
    logic [1:0]     r_state,   n_state;
    logic [IW-1:0]  r_count,   n_count;
    logic [IW-1:0]  r_sel,     n_sel;
    logic           r_present, n_present;
    logic [IW-1:0]  r_step,    n_step;
    logic [1:0]     r_drain,   n_drain;
    logic           r_ovalid,  n_ovalid;
    logic           r_have,    n_have;

    // Payload.
    logic [CB-1:0]      r_px;
    logic [CB-1:0]      r_py;
    logic [2*CB:0]      r_best_d;
    logic [IW-1:0]      r_best_idx;
    logic [OUT_DW-1:0]  r_odata, n_odata;

    logic [CB-1:0]  w_in_x;
    logic [CB-1:0]  w_in_y;
    logic           w_acc;
    logic           w_add_ok;
    logic           w_move_ok;
    logic           w_wr_en;
    logic [IW-1:0]  w_wr_idx;
    logic           w_shift;
    logic           w_start_scan;

    logic           w_feed_cand;
    logic           w_p_cand;
    logic [IW-1:0]  w_p_idx;
    logic [2*CB:0]  w_p_dist;
    logic           w_better;

    logic [IW+OUT_IDX_BITS-1:0] w_cnt_ext;
    logic [IW+OUT_IDX_BITS-1:0] w_sel_ext;

    logic [CB-1:0]  c_x [N];
    logic [CB-1:0]  c_y [N];

    assign w_in_x = s_axis_tdata[CB-1:0];
    assign w_in_y = s_axis_tdata[2*CB-1:CB];

    // A word is taken only at rest, and only when the result slot is free or freeing.
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_add_ok  = (r_count != IW'(MAX_VERTS - 1));
    assign w_move_ok = r_present && (r_sel < r_count);

    always_comb begin
        w_wr_en  = 1'b0;
        w_wr_idx = r_count;
        if (w_acc) begin
            case (s_axis_tuser)
                OP_ADD: begin
                    w_wr_en  = w_add_ok;
                    w_wr_idx = r_count;
                end
                OP_MOVE: begin
                    w_wr_en  = w_move_ok;
                    w_wr_idx = r_sel;
                end
                default: begin
                    w_wr_en = 1'b0;
                end
            endcase
        end
    end

    assign w_shift      = (r_state == ST_SCAN);
    assign w_start_scan = w_acc && (s_axis_tuser == OP_SELECT) && (r_count != '0);

    // The ring: cell i takes cell i+1 on every scan cycle, so after step k the head
    // (cell 0) holds slot k, and after a full rotation every slot is home again.
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        localparam int NXT = (gi + 1) % N;
        t_cell_ctl w_ctl;

        assign w_ctl.shift = w_shift;
        assign w_ctl.load  = w_wr_en && (w_wr_idx == IW'(gi));

        vsn_cell #(
            .COORD_BITS (CB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_nbr_x (c_x[NXT]),
            .i_nbr_y (c_y[NXT]),
            .i_wr_x  (w_in_x),
            .i_wr_y  (w_in_y),
            .o_x     (c_x[gi]),
            .o_y     (c_y[gi])
        );
    end

    // Only slots below the count are candidates; the rest of the ring just rides along.
    assign w_feed_cand = w_shift && (r_step < r_count);

    vsn_dist #(
        .COORD_BITS (CB),
        .IW         (IW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (w_feed_cand),
        .i_idx   (r_step),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_vx    (c_x[0]),
        .i_vy    (c_y[0]),
        .o_cand  (w_p_cand),
        .o_idx   (w_p_idx),
        .o_dist  (w_p_dist)
    );

    // Strictly smaller wins, so on a tie the earlier (lower) slot is kept.
    assign w_better = w_p_cand && (!r_have || (w_p_dist < r_best_d));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sel     = r_sel;
        n_present = r_present;
        n_step    = r_step;
        n_drain   = r_drain;
        n_have    = r_have || w_better;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;
        w_cnt_ext = '0;
        w_sel_ext = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (w_start_scan) begin
                        n_state = ST_SCAN;
                        n_step  = '0;
                        n_have  = 1'b0;
                    end else begin
                        if ((s_axis_tuser == OP_ADD) && w_add_ok) begin
                            n_count = r_count + 1'b1;
                        end
                        w_cnt_ext = {{OUT_IDX_BITS{1'b0}}, n_count};
                        w_sel_ext = {{OUT_IDX_BITS{1'b0}}, r_present ? r_sel : {IW{1'b0}}};
                        n_ovalid  = 1'b1;
                        n_odata   = pack_out(w_wr_en, r_present,
                                             w_sel_ext[OUT_IDX_BITS-1:0],
                                             w_cnt_ext[OUT_IDX_BITS-1:0]);
                    end
                end
            end
            ST_SCAN: begin
                n_step = r_step + 1'b1;
                if (r_step == IW'(MAX_VERTS - 1)) begin
                    n_state = ST_DRAIN;
                    n_drain = '0;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == 2'd2) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state   = ST_IDLE;
                n_sel     = r_best_idx;
                n_present = 1'b1;
                w_cnt_ext = {{OUT_IDX_BITS{1'b0}}, r_count};
                w_sel_ext = {{OUT_IDX_BITS{1'b0}}, r_best_idx};
                n_ovalid  = 1'b1;
                n_odata   = pack_out(1'b1, 1'b1,
                                     w_sel_ext[OUT_IDX_BITS-1:0],
                                     w_cnt_ext[OUT_IDX_BITS-1:0]);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_sel     <= '0;
            r_present <= 1'b0;
            r_step    <= '0;
            r_drain   <= '0;
            r_ovalid  <= 1'b0;
            r_have    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sel     <= n_sel;
            r_present <= n_present;
            r_step    <= n_step;
            r_drain   <= n_drain;
            r_ovalid  <= n_ovalid;
            r_have    <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        if (w_start_scan) begin
            r_px <= w_in_x;
            r_py <= w_in_y;
        end
        if (w_better) begin
            r_best_d   <= w_p_dist;
            r_best_idx <= w_p_idx;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

### rtl/vsn_cell.sv
// One vertex cell of the rotating store ring.
module vsn_cell
    import vsn_pkg::*;
#(
    parameter int COORD_BITS = VSN_COORD_BITS
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [COORD_BITS-1:0] i_nbr_x,
    input  logic [COORD_BITS-1:0] i_nbr_y,
    input  logic [COORD_BITS-1:0] i_wr_x,
    input  logic [COORD_BITS-1:0] i_wr_y,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y
);

    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;

    // A load only happens while the ring is at rest, so the two never meet.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end else if (i_ctl.shift) begin
            r_x <= i_nbr_x;
            r_y <= i_nbr_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

### rtl/vsn_dist.sv
// Three-stage squared-distance pipeline fed from the head of the ring.
module vsn_dist
    import vsn_pkg::*;
#(
    parameter int COORD_BITS = VSN_COORD_BITS,
    parameter int IW         = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cand,
    input  logic [IW-1:0]           i_idx,
    input  logic [COORD_BITS-1:0]   i_px,
    input  logic [COORD_BITS-1:0]   i_py,
    input  logic [COORD_BITS-1:0]   i_vx,
    input  logic [COORD_BITS-1:0]   i_vy,
    output logic                    o_cand,
    output logic [IW-1:0]           o_idx,
    output logic [2*COORD_BITS:0]   o_dist
);

    localparam int CB = COORD_BITS;

    logic signed [CB:0] w_diff_x;
    logic signed [CB:0] w_diff_y;
    logic [CB:0]        w_abs_x;
    logic [CB:0]        w_abs_y;

    logic [2:0]         r_cand;
    logic [IW-1:0]      r_idx1;
    logic [IW-1:0]      r_idx2;
    logic [IW-1:0]      r_idx3;
    logic [CB-1:0]      r_dx;
    logic [CB-1:0]      r_dy;
    logic [2*CB-1:0]    r_sqx;
    logic [2*CB-1:0]    r_sqy;
    logic [2*CB:0]      r_sum;

    // Differences fit in CB+1 signed bits; their magnitudes fit in CB bits.
    assign w_diff_x = $signed({i_px[CB-1], i_px}) - $signed({i_vx[CB-1], i_vx});
    assign w_diff_y = $signed({i_py[CB-1], i_py}) - $signed({i_vy[CB-1], i_vy});
    assign w_abs_x  = w_diff_x[CB] ? -w_diff_x : w_diff_x;
    assign w_abs_y  = w_diff_y[CB] ? -w_diff_y : w_diff_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else begin
            r_cand <= {r_cand[1:0], i_cand};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= w_abs_x[CB-1:0];
        r_dy   <= w_abs_y[CB-1:0];
        r_idx1 <= i_idx;
        r_sqx  <= {{CB{1'b0}}, r_dx} * {{CB{1'b0}}, r_dx};
        r_sqy  <= {{CB{1'b0}}, r_dy} * {{CB{1'b0}}, r_dy};
        r_idx2 <= r_idx1;
        r_sum  <= {1'b0, r_sqx} + {1'b0, r_sqy};
        r_idx3 <= r_idx2;
    end

    assign o_cand = r_cand[2];
    assign o_idx  = r_idx3;
    assign o_dist = r_sum;

endmodule

### rtl/vsn_checker.sv
// Port-level checks for the vertex store nearest-select block, bound to the top level.
module vsn_checker
    import vsn_pkg::*;
#(
    parameter int MAX_VERTS = VSN_MAX_VERTS
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_DW-1:0] m_axis_tdata
);

    logic r_seen_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_sel <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[1]) begin
            r_seen_sel <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> (m_axis_tdata[7:2] == 6'd0))
        else $error("selected index not zero without a selection");

    a_sel_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen_sel |-> m_axis_tdata[1])
        else $error("selection lost after it was reported");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (MAX_VERTS > 64) || (int'(m_axis_tdata[13:8]) < MAX_VERTS))
        else $error("vertex count beyond store size");

endmodule

bind vertex_store_nearest_select_core vsn_checker #(
    .MAX_VERTS (MAX_VERTS)
) u_vsn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/vsn_result_checker.sv
// Checker for the vertex store: predicts each result word and compares it with the output.
module vsn_result_checker
    import vsn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    // Command tdata: x_coord, then y_coord.
    input  logic [31:0]       i_in_data,
    // Command tuser: operation.
    input  logic [1:0]        i_in_user,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    // Result tdata: applied, selection_valid, selected_index, vertex_count.
    input  logic [OUT_DW-1:0] i_out_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [OUT_IDX_BITS-1:0] count;
        logic [OUT_IDX_BITS-1:0] idx;
        logic                    sel_valid;
        logic                    applied;
    } t_status;

    // Shadow copy of the vertex store and the selection.
    logic signed [VSN_COORD_BITS-1:0] vert_x [VSN_MAX_VERTS];
    logic signed [VSN_COORD_BITS-1:0] vert_y [VSN_MAX_VERTS];
    int unsigned n_verts;
    int unsigned sel_slot;
    bit          sel_present;
    t_status     expected_status[$];

    function automatic longint sq_dist(
        input logic signed [VSN_COORD_BITS-1:0] ax,
        input logic signed [VSN_COORD_BITS-1:0] ay,
        input logic signed [VSN_COORD_BITS-1:0] bx,
        input logic signed [VSN_COORD_BITS-1:0] by
    );
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    // Applies one command to the shadow store and queues the status it leaves.
    task automatic apply_vertex_op(
        input logic [1:0]                       op,
        input logic signed [VSN_COORD_BITS-1:0] px,
        input logic signed [VSN_COORD_BITS-1:0] py
    );
        t_status     r;
        int unsigned best;
        int unsigned i;
        longint      best_d;
        longint      d;
        r = '0;
        case (op)
            OP_ADD: begin
                if (n_verts < VSN_MAX_VERTS - 1) begin
                    vert_x[n_verts] = px;
                    vert_y[n_verts] = py;
                    n_verts++;
                    r.applied = 1'b1;
                end
            end
            OP_MOVE: begin
                if (sel_present && sel_slot < n_verts) begin
                    vert_x[sel_slot] = px;
                    vert_y[sel_slot] = py;
                    r.applied = 1'b1;
                end
            end
            OP_SELECT: begin
                // Strict less-than keeps the lowest index on a tie.
                if (n_verts > 0) begin
                    best = 0;
                    best_d = sq_dist(px, py, vert_x[0], vert_y[0]);
                    for (i = 1; i < n_verts; i++) begin
                        d = sq_dist(px, py, vert_x[i], vert_y[i]);
                        if (d < best_d) begin
                            best = i;
                            best_d = d;
                        end
                    end
                    sel_slot = best;
                    sel_present = 1'b1;
                    r.applied = 1'b1;
                end
            end
            default: ;
        endcase
        r.sel_valid = sel_present;
        r.idx = sel_present ? OUT_IDX_BITS'(sel_slot) : '0;
        r.count = OUT_IDX_BITS'(n_verts);
        expected_status.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] got);
        if (got !== expv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_status exp_r;
        t_status got;
        if (!i_rst_n) begin
            n_verts = 0;
            sel_slot = 0;
            sel_present = 1'b0;
            expected_status.delete();
            o_errors = 0;
            o_checked = 0;
        end else begin
            // The output side is handled first: a result taken at this edge
            // always belongs to a command taken at an earlier edge.
            if (i_out_valid && i_out_ready) begin
                got.applied = i_out_data[0];
                got.sel_valid = i_out_data[1];
                got.idx = i_out_data[7:2];
                got.count = i_out_data[13:8];
                if (expected_status.size() == 0) begin
                    $error("result word %h arrived with no command outstanding", i_out_data);
                    o_errors++;
                end else begin
                    exp_r = expected_status.pop_front();
                    o_checked++;
                    check_field("applied", 8'(exp_r.applied), 8'(got.applied));
                    check_field("selection_valid", 8'(exp_r.sel_valid), 8'(got.sel_valid));
                    check_field("selected_index", 8'(exp_r.idx), 8'(got.idx));
                    check_field("vertex_count", 8'(exp_r.count), 8'(got.count));
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_vertex_op(i_in_user, i_in_data[15:0], i_in_data[31:16]);
            end
        end
        o_pending = expected_status.size();
    end

endmodule

### bench/tb_vertex_store_nearest_select_core.sv
// Testbench top for the vertex store with nearest-vertex selection: stimulus and verdict.
module tb_vertex_store_nearest_select_core;
    import vsn_pkg::*;

    // The block ignores this code; it is sent to check that nothing changes.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int N_RANDOM    = 930;
    // Idling stops for the last words of the run.
    localparam int QUIET_TAIL  = 120;
    // The long output stall starts once this many command words have gone in.
    localparam int HOLD_AT     = 350;
    localparam int LONG_HOLD   = 400;
    // Leaves ample room for a select on a full store, which runs a full ring rotation.
    localparam int DRAIN_WAIT  = 2 * VSN_MAX_VERTS + 16;
    localparam int CYCLE_LIMIT = 600000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // tdata: x_coord in bits 15:0, y_coord in bits 31:16.
    logic [31:0]       s_axis_tdata;
    // tuser: operation.
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // tdata: applied, selection_valid, selected_index, vertex_count, from bit 0 up.
    logic [OUT_DW-1:0] m_axis_tdata;

    int errors;
    int pending;
    int checked;

    // Shared between the command process and the output-side process.
    int sent_total;
    bit quiet;

    int n_add;
    int n_move;
    int n_sel;
    int n_unused;

    vertex_store_nearest_select_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    vsn_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one command word and holds it until the block takes it. All
    // driving happens at the falling edge, so the block and the checker see
    // stable values at the rising edge. A random gap may come first.
    task automatic send_word(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent_total++;
        case (op)
            OP_ADD:    n_add++;
            OP_MOVE:   n_move++;
            OP_SELECT: n_sel++;
            default:   n_unused++;
        endcase
    endtask

    // Coordinates lean toward the extremes and toward a small window around
    // the origin, where equal distances and hence ties are common.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3, 4: return 16'($urandom_range(0, 16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return OP_ADD;
        if (r < 50) return OP_MOVE;
        if (r < 95) return OP_SELECT;
        return OP_UNUSED;
    endfunction

    // Command side and verdict.
    initial begin
        int i;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ADD;
        sent_total = 0;
        quiet = 1'b0;
        n_add = 0;
        n_move = 0;
        n_sel = 0;
        n_unused = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty store: select, move and the unused code all leave state alone.
        send_word(OP_SELECT, 16'h0000, 16'h0000);
        send_word(OP_MOVE, 16'h0005, 16'h0005);
        send_word(OP_UNUSED, 16'hffff, 16'hffff);
        // Corners, the origin and a duplicate of the origin.
        send_word(OP_ADD, 16'h8000, 16'h8000);
        send_word(OP_ADD, 16'h7fff, 16'h7fff);
        send_word(OP_ADD, 16'h0000, 16'h0000);
        send_word(OP_ADD, 16'h8000, 16'h7fff);
        send_word(OP_ADD, 16'h7fff, 16'h8000);
        send_word(OP_ADD, 16'h0000, 16'h0000);
        // Exact hits on corners and on the origin, where two slots tie.
        send_word(OP_SELECT, 16'h7fff, 16'h7fff);
        send_word(OP_SELECT, 16'h8000, 16'h8000);
        send_word(OP_SELECT, 16'h0000, 16'h0000);
        send_word(OP_SELECT, 16'h7fff, 16'h8000);
        // Two different vertices at equal distance from the query point.
        send_word(OP_ADD, 16'h0002, 16'h0000);
        send_word(OP_SELECT, 16'h0001, 16'h0000);
        send_word(OP_MOVE, 16'h8000, 16'h0000);
        send_word(OP_SELECT, 16'h0001, 16'h0000);
        // Moving a vertex onto another one makes an exact tie.
        send_word(OP_MOVE, 16'h7fff, 16'h7fff);
        send_word(OP_SELECT, 16'h7fff, 16'h7fff);
        send_word(OP_UNUSED, 16'h7fff, 16'h8000);
        send_word(OP_SELECT, 16'hffff, 16'hffff);

        // Random part. The store fills within the first couple of hundred
        // words, after which adds exercise the full-store case.
        for (i = 0; i < N_RANDOM; i++) begin
            if (i >= N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            send_word(rand_op(), rand_coord(), rand_coord());
        end
        s_axis_tvalid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Sent %0d command words: %0d add, %0d move, %0d select, %0d unused code.",
                 sent_total, n_add, n_move, n_sel, n_unused);
        $display("Checked %0d result words, including a %0d-cycle output stall.",
                 checked, LONG_HOLD);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Output side: short random stalls, one long stall that backs the block
    // up into its input, and no stalls in the quiet tail of the run.
    initial begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_done && sent_total >= HOLD_AT) begin
                long_done = 1'b1;
                hold = LONG_HOLD;
            end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 11);
            end
            if (hold > 0) begin
                m_axis_tready = 1'b0;
                hold--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### vertex_store_nearest_select_core.f
rtl/vsn_pkg.sv
rtl/vsn_cell.sv
rtl/vsn_dist.sv
rtl/vertex_store_nearest_select_core.sv
rtl/vsn_checker.sv
bench/vsn_result_checker.sv
bench/tb_vertex_store_nearest_select_core.sv
